>>> src/fol_pkg.sv
// ----------------------------------------------------------------------------
// Frequency-ordered lookup table package
// Field widths, mode and status codes and the result beat shared by the
// lookup table core and its response register.
// ----------------------------------------------------------------------------
package fol_pkg;

   localparam int MODE_BITS   = 2;
   localparam int KEY_BITS    = 32;
   localparam int INDEX_BITS  = 6;
   localparam int STATUS_BITS = 3;
   localparam int POS_BITS    = 6;
   localparam int HIT_BITS    = 16;
   localparam int OCC_BITS    = 7;

   localparam logic [MODE_BITS-1:0] MODE_APPEND = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_LOOKUP = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_READ   = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_APPENDED  = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_FOUND     = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_READ_OK   = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_BAD_INDEX = 3'd5;

   typedef struct packed {
      logic [STATUS_BITS-1:0]     status;
      logic [POS_BITS-1:0]        old_position;
      logic [POS_BITS-1:0]        new_position;
      logic [HIT_BITS-1:0]        hit_count;
      logic signed [KEY_BITS-1:0] entry_key;
      logic [OCC_BITS-1:0]        occupancy;
   } result_type;

endpackage

>>> src/fol_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
module fol_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/fol_rsp_reg.sv
// ----------------------------------------------------------------------------
// Response output register
// Holds one result beat until the receiver takes it, and tells the core
// when a new beat may be loaded.
// ----------------------------------------------------------------------------
module fol_rsp_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  fol_pkg::result_type load_data,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fol_pkg::result_type rsp_data
);

   import fol_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;
   result_type data_in;

   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);
   assign data_in  = load ? load_data : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> src/frequency_ordered_lookup_table_core.sv
// ----------------------------------------------------------------------------
// Frequency-ordered lookup table core
// An ordered table of keys with hit counts, kept in descending count order.
//
//   Channel   Direction  Handshake            Beat contents
//   req_      in         req_valid/req_stall  mode, key, index
//   rsp_      out        rsp_valid/rsp_stall  status, positions, count, key, fill
//
// A lookup scans the RAM one entry per cycle from the front and, on a hit
// at position p that moves to position j, shifts entries back one per
// cycle; a hit at the front needs no shift, and a miss scans every filled
// entry. The single RAM read port is why the scan and the shift go one
// entry at a time. One item is in work at a time.
// Reset empties the table at once; no clearing pass is needed.
// A stalled result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module frequency_ordered_lookup_table_core #(
   parameter int DEPTH      = 64,
   parameter int COUNT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [fol_pkg::MODE_BITS-1:0]         req_mode,
   input  logic signed [fol_pkg::KEY_BITS-1:0]   req_key,
   input  logic [fol_pkg::INDEX_BITS-1:0]        req_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [fol_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic [fol_pkg::POS_BITS-1:0]          rsp_old_position,
   output logic [fol_pkg::POS_BITS-1:0]          rsp_new_position,
   output logic [fol_pkg::HIT_BITS-1:0]          rsp_hit_count,
   output logic signed [fol_pkg::KEY_BITS-1:0]   rsp_entry_key,
   output logic [fol_pkg::OCC_BITS-1:0]          rsp_occupancy
);

   import fol_pkg::*;

   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int LEVEL_BITS = $clog2(DEPTH + 1);
   localparam int CMP_BITS   = (LEVEL_BITS > INDEX_BITS) ? LEVEL_BITS : INDEX_BITS;
   localparam int ENTRY_BITS = KEY_BITS + COUNT_BITS;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]                 state_ff, state_in;
   logic [LEVEL_BITS-1:0]      fill_ff, fill_in;
   logic signed [KEY_BITS-1:0] key_ff, key_in;
   logic [ADDR_BITS-1:0]       ptr_ff, ptr_in;
   logic [ADDR_BITS-1:0]       hit_pos_ff, hit_pos_in;
   logic [COUNT_BITS-1:0]      count_ff, count_in;
   result_type                 res_ff, res_in;

   logic                       mem_we;
   logic [ADDR_BITS-1:0]       mem_waddr;
   logic [ENTRY_BITS-1:0]      mem_wdata;
   logic [ADDR_BITS-1:0]       mem_raddr;
   logic [ENTRY_BITS-1:0]      mem_rdata;

   logic signed [KEY_BITS-1:0] rd_key;
   logic [COUNT_BITS-1:0]      rd_count;
   logic [COUNT_BITS-1:0]      rd_count_inc;
   logic [LEVEL_BITS-1:0]      next_ptr_level;
   logic [CMP_BITS-1:0]        index_ext;
   logic [CMP_BITS-1:0]        fill_ext;
   logic                       accept;
   logic                       rsp_free;
   logic                       rsp_load;
   result_type                 rsp_load_data;
   result_type                 rsp_data;

   fol_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (DEPTH)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign rd_key         = mem_rdata[ENTRY_BITS-1 -: KEY_BITS];
   assign rd_count       = mem_rdata[COUNT_BITS-1:0];
   assign rd_count_inc   = (rd_count == COUNT_MAX) ? rd_count : rd_count + 1'b1;
   assign next_ptr_level = LEVEL_BITS'(ptr_ff) + LEVEL_BITS'(1);
   assign index_ext      = CMP_BITS'(req_index);
   assign fill_ext       = CMP_BITS'(fill_ff);

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      key_in     = key_ff;
      ptr_in     = ptr_ff;
      hit_pos_in = hit_pos_ff;
      count_in   = count_ff;
      res_in     = res_ff;
      mem_we     = 1'b0;
      mem_waddr  = ptr_ff;
      mem_wdata  = {key_ff, count_ff};
      mem_raddr  = ptr_ff;
      rsp_load   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in   = req_key;
               res_in   = '0;
               state_in = S_DONE;
               unique case (req_mode)
                  MODE_APPEND: begin
                     if (fill_ff >= LEVEL_BITS'(DEPTH)) begin
                        res_in.status = ST_FULL;
                     end else begin
                        mem_we              = 1'b1;
                        mem_waddr           = fill_ff[ADDR_BITS-1:0];
                        mem_wdata           = {req_key, COUNT_BITS'(0)};
                        fill_in             = fill_ff + 1'b1;
                        res_in.status       = ST_APPENDED;
                        res_in.old_position = POS_BITS'(fill_ff);
                        res_in.new_position = POS_BITS'(fill_ff);
                     end
                  end
                  MODE_LOOKUP: begin
                     if (fill_ff == '0) begin
                        res_in.status = ST_NOT_FOUND;
                     end else begin
                        mem_raddr = '0;
                        ptr_in    = '0;
                        state_in  = S_SCAN;
                     end
                  end
                  MODE_READ: begin
                     if (index_ext < fill_ext) begin
                        mem_raddr = index_ext[ADDR_BITS-1:0];
                        state_in  = S_READ;
                     end else begin
                        res_in.status = ST_BAD_INDEX;
                     end
                  end
                  default: begin
                     res_in.status = ST_BAD_INDEX;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (rd_key == key_ff) begin
               count_in   = rd_count_inc;
               hit_pos_in = ptr_ff;
               if (ptr_ff == '0) begin
                  mem_we              = 1'b1;
                  mem_waddr           = '0;
                  mem_wdata           = {key_ff, rd_count_inc};
                  res_in              = '0;
                  res_in.status       = ST_FOUND;
                  res_in.hit_count    = HIT_BITS'(rd_count_inc);
                  state_in            = S_DONE;
               end else begin
                  mem_raddr = ptr_ff - 1'b1;
                  state_in  = S_SHIFT;
               end
            end else if (next_ptr_level >= fill_ff) begin
               res_in        = '0;
               res_in.status = ST_NOT_FOUND;
               state_in      = S_DONE;
            end else begin
               mem_raddr = ptr_ff + 1'b1;
               ptr_in    = ptr_ff + 1'b1;
            end
         end
         S_SHIFT: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            if (ptr_ff == '0 || rd_count >= count_ff) begin
               mem_wdata           = {key_ff, count_ff};
               res_in              = '0;
               res_in.status       = ST_FOUND;
               res_in.old_position = POS_BITS'(hit_pos_ff);
               res_in.new_position = POS_BITS'(ptr_ff);
               res_in.hit_count    = HIT_BITS'(count_ff);
               state_in            = S_DONE;
            end else begin
               mem_wdata = mem_rdata;
               mem_raddr = ptr_ff - ADDR_BITS'(2);
               ptr_in    = ptr_ff - 1'b1;
            end
         end
         S_READ: begin
            res_in           = '0;
            res_in.status    = ST_READ_OK;
            res_in.hit_count = HIT_BITS'(rd_count);
            res_in.entry_key = rd_key;
            state_in         = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_load_data           = res_ff;
      rsp_load_data.occupancy = OCC_BITS'(fill_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      ptr_ff     <= ptr_in;
      hit_pos_ff <= hit_pos_in;
      count_ff   <= count_in;
      res_ff     <= res_in;
   end

   fol_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .load_data (rsp_load_data),
      .free      (rsp_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_status       = rsp_data.status;
   assign rsp_old_position = rsp_data.old_position;
   assign rsp_new_position = rsp_data.new_position;
   assign rsp_hit_count    = rsp_data.hit_count;
   assign rsp_entry_key    = rsp_data.entry_key;
   assign rsp_occupancy    = rsp_data.occupancy;

   // The table never holds more entries than it has slots.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LEVEL_BITS'(DEPTH))
      else $error("fill level exceeds table depth");

   // Entries are never removed, so the fill level never drops.
   a_fill_monotonic: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |=> fill_ff == $past(fill_ff))
      else $error("fill level changed during a lookup or read");

   // The scan pointer stays inside the filled part of the table.
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_SHIFT) |-> LEVEL_BITS'(ptr_ff) < fill_ff)
      else $error("scan pointer beyond fill level");

   // The hit entry only moves toward the front.
   a_shift_forward: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT |-> ptr_ff <= hit_pos_ff)
      else $error("shift slot behind the hit position");

   // No table write while a read result or a finished result is pending.
   a_no_late_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ || state_ff == S_DONE) |-> !mem_we)
      else $error("table written outside an update");

endmodule
